// ===== hw/rtl/tshi_pkg.sv =====
// ----------------------------------------------------------------------------
// tshi_pkg: shared types and constants
// Grid sizes, datapath widths and smoothstep weight function for the
// sub-cell height interpolator. Grid sizes must be powers of two.
// ----------------------------------------------------------------------------
`default_nettype none
package tshi_pkg;

    localparam int SIZE_X = 8;
    localparam int SIZE_Z = 8;
    localparam int SIZE_M = (SIZE_X > SIZE_Z) ? SIZE_X : SIZE_Z;

    localparam int IN_W   = 16;
    localparam int X_W    = $clog2(SIZE_X);
    localparam int Z_W    = $clog2(SIZE_Z);
    localparam int IDX_W  = 3;

    localparam int P_C    = 2 * SIZE_X;
    localparam int Q_C    = 2 * SIZE_Z;
    localparam int PQ_C   = P_C * Q_C;
    localparam int P3_C   = P_C * P_C * P_C;
    localparam int Q3_C   = Q_C * Q_C * Q_C;

    // corner sums and slopes
    localparam int S_W    = IN_W + 2;
    localparam int OFF_W  = $clog2(2 * SIZE_M) + 2;
    localparam int W_W    = $clog2(8 * SIZE_M * SIZE_M * SIZE_M + 1);
    localparam int N_W    = S_W + 2 * $clog2(2 * SIZE_M) + 3;
    localparam int ROW_W  = N_W + W_W;
    localparam int NUM_W  = ROW_W + W_W;
    localparam int DEN_SH = 2 + 4 * $clog2(P_C) + 4 * $clog2(Q_C);

    typedef logic signed [S_W-1:0]   sval_t;
    typedef logic signed [OFF_W-1:0] off_t;
    typedef logic [W_W-1:0]          wgt_t;
    typedef logic signed [N_W-1:0]   plane_t;
    typedef logic signed [ROW_W-1:0] row_t;
    typedef logic signed [NUM_W-1:0] num_t;

    typedef struct packed {
        sval_t s1, s2, s3, s4;
        sval_t aau, aav, abu, abv;
        sval_t bau, bav, bbu, bbv;
    } coef_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Z_W-1:0] z;
        logic           last;
    } tag_t;

    // smoothstep numerator p*p*(3P-2p), p = 2*idx+1, P = 2*size
    function automatic wgt_t fade(input int idx, input int size);
        int p;
        int pp;
        p  = 2 * idx + 1;
        pp = 2 * size;
        return W_W'(p * p * (3 * pp - 2 * p));
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tshi_plane_cell.sv =====
// ----------------------------------------------------------------------------
// tshi_plane_cell: one plane numerator
// Forms S*P*Q + 2Q*du*ou + 2P*dv*ov and registers it.
// ----------------------------------------------------------------------------
`default_nettype none
module tshi_plane_cell (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire tshi_pkg::sval_t  s,
    input  wire tshi_pkg::sval_t  du,
    input  wire tshi_pkg::sval_t  dv,
    input  wire tshi_pkg::off_t   ou,
    input  wire tshi_pkg::off_t   ov,
    output tshi_pkg::plane_t      n_reg
);
    import tshi_pkg::*;

    plane_t n_next;

    always_comb begin
        n_next = plane_t'(s) * plane_t'(PQ_C)
               + plane_t'(du) * plane_t'(ou) * plane_t'(2 * Q_C)
               + plane_t'(dv) * plane_t'(ov) * plane_t'(2 * P_C);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tshi_blend_cell.sv =====
// ----------------------------------------------------------------------------
// tshi_blend_cell: weighted blend of two values
// Registers a*wc + b*w, where w + wc is the full weight.
// ----------------------------------------------------------------------------
`default_nettype none
module tshi_blend_cell (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire tshi_pkg::row_t  a,
    input  wire tshi_pkg::row_t  b,
    input  wire tshi_pkg::wgt_t  w,
    input  wire tshi_pkg::wgt_t  wc,
    output tshi_pkg::num_t       y_reg
);
    import tshi_pkg::*;

    num_t y_next;

    always_comb begin
        y_next = num_t'(a) * num_t'($signed({1'b0, wc}))
               + num_t'(b) * num_t'($signed({1'b0, w}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/terrain_subcell_height_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// terrain_subcell_height_interpolator_top: smoothstep plane interpolator
// Takes a cell and its eight neighbors, emits one height per sub-cell.
// ----------------------------------------------------------------------------
// channel | dir | payload
// s_      | in  | nine 16-bit heights: centre, nw, n, ne, e, se, s, sw, w
// m_      | out | sub_height, col_index, row_index; tlast on last sub-cell
//
// One item yields SIZE_X*SIZE_Z results (64), one per cycle while m_tready
// does not stall the chain; the sub-cell sequencer steps through them. The next item
// is taken in the cycle the last sub-cell issues, so items run back to back.
// From sequencer issue a result passes the plane, row, column and output registers.
// Reset clears the sequencer and the valid bits of the cell chain.
// A stall on m_tready freezes the whole chain; the output register holds.
// ----------------------------------------------------------------------------
`default_nettype none
module terrain_subcell_height_interpolator_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // centre, north_west, north, north_east, east, south_east, south,
    // south_west, west heights: 16 bits each from the lowest bit up
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // sub_height [15:0], col_index [18:16], row_index [21:19], zero pad
    output logic [23:0]       m_tdata,
    output logic              m_tlast
);
    import tshi_pkg::*;

    // chain advance: everything moves unless the output is stalled
    logic adv;
    logic s_fire;
    assign adv    = !m_tvalid || m_tready;
    assign s_fire = s_tvalid && s_tready;

    // ---- input coefficients ----
    sval_t e, e1, e2, e3, e4, e5, e6, e7, e8;
    coef_t coef_next;

    always_comb begin
        e  = sval_t'($signed(s_tdata[15:0]));
        e1 = sval_t'($signed(s_tdata[31:16]));
        e2 = sval_t'($signed(s_tdata[47:32]));
        e3 = sval_t'($signed(s_tdata[63:48]));
        e4 = sval_t'($signed(s_tdata[79:64]));
        e5 = sval_t'($signed(s_tdata[95:80]));
        e6 = sval_t'($signed(s_tdata[111:96]));
        e7 = sval_t'($signed(s_tdata[127:112]));
        e8 = sval_t'($signed(s_tdata[143:128]));
        coef_next.s1  = e8 + e1 + e2 + e;
        coef_next.s2  = e2 + e3 + e4 + e;
        coef_next.s3  = e4 + e5 + e6 + e;
        coef_next.s4  = e6 + e7 + e8 + e;
        coef_next.aau = (e2 + e) - (e1 + e8);
        coef_next.aav = (e1 + e2) - (e8 + e);
        coef_next.abu = (e3 + e4) - (e2 + e);
        coef_next.abv = (e2 + e3) - (e + e4);
        coef_next.bau = (e + e6) - (e8 + e7);
        coef_next.bav = (e8 + e) - (e7 + e6);
        coef_next.bbu = (e4 + e5) - (e + e6);
        coef_next.bbv = (e + e4) - (e6 + e5);
    end

    // ---- sub-cell sequencer ----
    coef_t          coef_reg;
    logic           busy_reg;
    logic [X_W-1:0] x_reg;
    logic [Z_W-1:0] z_reg;
    logic           at_last;

    assign at_last  = (x_reg == X_W'(SIZE_X - 1)) && (z_reg == Z_W'(SIZE_Z - 1));
    // hold input off while in reset
    assign s_tready = aresetn && adv && (!busy_reg || at_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            x_reg    <= '0;
            z_reg    <= '0;
        end else if (adv) begin
            if (!busy_reg || at_last) begin
                busy_reg <= s_fire;
                x_reg    <= '0;
                z_reg    <= '0;
            end else if (x_reg == X_W'(SIZE_X - 1)) begin
                x_reg <= '0;
                z_reg <= z_reg + 1'b1;
            end else begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            coef_reg <= coef_next;
        end
    end

    // ---- stage 1: plane cells ----
    off_t u_near, u_far, v_near, v_far;
    assign u_near = off_t'({x_reg, 1'b1});
    assign u_far  = u_near - off_t'(P_C);
    assign v_near = off_t'({z_reg, 1'b1});
    assign v_far  = v_near - off_t'(Q_C);

    plane_t n1_reg, n2_reg, n3_reg, n4_reg;

    tshi_plane_cell u_plane4 (.aclk(aclk), .en(adv), .s(coef_reg.s4), .du(coef_reg.bau),
        .dv(coef_reg.bav), .ou(u_near), .ov(v_near), .n_reg(n4_reg));
    tshi_plane_cell u_plane3 (.aclk(aclk), .en(adv), .s(coef_reg.s3), .du(coef_reg.bbu),
        .dv(coef_reg.bbv), .ou(u_far), .ov(v_near), .n_reg(n3_reg));
    tshi_plane_cell u_plane1 (.aclk(aclk), .en(adv), .s(coef_reg.s1), .du(coef_reg.aau),
        .dv(coef_reg.aav), .ou(u_near), .ov(v_far), .n_reg(n1_reg));
    tshi_plane_cell u_plane2 (.aclk(aclk), .en(adv), .s(coef_reg.s2), .du(coef_reg.abu),
        .dv(coef_reg.abv), .ou(u_far), .ov(v_far), .n_reg(n2_reg));

    logic v1_reg, v2_reg, v3_reg;
    tag_t tag1_reg, tag2_reg, tag3_reg;
    wgt_t fu_reg, fuc_reg, fv1_reg, fvc1_reg, fv2_reg, fvc2_reg;
    wgt_t fu_next, fv_next;

    always_comb begin
        fu_next = fade(int'(x_reg), SIZE_X);
        fv_next = fade(int'(z_reg), SIZE_Z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= busy_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg <= '{x: x_reg, z: z_reg, last: at_last};
            fu_reg   <= fu_next;
            fuc_reg  <= wgt_t'(P3_C) - fu_next;
            fv1_reg  <= fv_next;
            fvc1_reg <= wgt_t'(Q3_C) - fv_next;
            tag2_reg <= tag1_reg;
            fv2_reg  <= fv1_reg;
            fvc2_reg <= fvc1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // ---- stage 2: blend along u ----
    num_t row0_reg, row1_reg;

    tshi_blend_cell u_row0 (.aclk(aclk), .en(adv), .a(row_t'(n4_reg)), .b(row_t'(n3_reg)),
        .w(fu_reg), .wc(fuc_reg), .y_reg(row0_reg));
    tshi_blend_cell u_row1 (.aclk(aclk), .en(adv), .a(row_t'(n1_reg)), .b(row_t'(n2_reg)),
        .w(fu_reg), .wc(fuc_reg), .y_reg(row1_reg));

    // ---- stage 3: blend along v ----
    num_t num_reg;

    tshi_blend_cell u_col (.aclk(aclk), .en(adv), .a(row_t'(row0_reg)),
        .b(row_t'(row1_reg)), .w(fv2_reg), .wc(fvc2_reg), .y_reg(num_reg));

    // ---- stage 4: truncate toward zero, saturate, output register ----
    num_t               biased;
    num_t               quo;
    logic signed [15:0] h_next;

    always_comb begin
        biased = num_reg + (num_reg[NUM_W-1] ? num_t'((64'd1 << DEN_SH) - 64'd1) : '0);
        quo    = biased >>> DEN_SH;
        if (quo > num_t'(32767)) begin
            h_next = 16'sh7fff;
        end else if (quo < -num_t'(32768)) begin
            h_next = -16'sh8000;
        end else begin
            h_next = quo[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (adv) begin
            m_tvalid <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata <= {2'b00, IDX_W'(tag3_reg.z), IDX_W'(tag3_reg.x), h_next};
            m_tlast <= tag3_reg.last;
        end
    end

    // ---- checks ----
    a_ready_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> adv)
        else $error("input taken while chain stalled");
    a_fire_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> busy_reg)
        else $error("sequencer idle after accept");
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[18:16] == IDX_W'(SIZE_X - 1)
            && m_tdata[21:19] == IDX_W'(SIZE_Z - 1)))
        else $error("tlast on wrong sub-cell");
endmodule
`default_nettype wire

// ===== dv/terrain_subcell_height_interpolator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_subcell_height_interpolator_top_tb: self-checking bench
// Drives cells of nine heights in bursts, predicts every sub-cell height of
// the blended-plane grid in exact integer math, and checks each result item.
// ----------------------------------------------------------------------------
`default_nettype none
module terrain_subcell_height_interpolator_top_tb;

    import tshi_pkg::*;

    localparam int RAND_CELLS = 480;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] h;
        logic [2:0]         col;
        logic [2:0]         row;
        logic               last;
    } subcell_t;

    // Hold the expected sub-cell heights and compare result items in order.
    class height_board;
        subcell_t pending[$];
        int       errors;
        int       checked;

        function longint plane(longint s, longint du, longint ou, longint dv,
                               longint ov, longint pp, longint qq);
            return s * pp * qq + 2 * qq * du * ou + 2 * pp * dv * ov;
        endfunction

        // Expand one cell into its whole grid of expected sub-cells.
        function void note_cell(logic [143:0] d);
            longint e[9];
            longint s1, s2, s3, s4, aau, aav, abu, abv, bau, bav, bbu, bbv;
            longint pp, qq, p3, q3, den, p, q, fu, fv, n1, n2, n3, n4, num, hh;
            subcell_t c;
            for (int i = 0; i < 9; i++) e[i] = longint'($signed(d[16*i +: 16]));
            s1 = e[8] + e[1] + e[2] + e[0];
            s2 = e[2] + e[3] + e[4] + e[0];
            s3 = e[4] + e[5] + e[6] + e[0];
            s4 = e[6] + e[7] + e[8] + e[0];
            aau = (e[2] + e[0]) - (e[1] + e[8]);
            aav = (e[1] + e[2]) - (e[8] + e[0]);
            abu = (e[3] + e[4]) - (e[2] + e[0]);
            abv = (e[2] + e[3]) - (e[0] + e[4]);
            bau = (e[0] + e[6]) - (e[8] + e[7]);
            bav = (e[8] + e[0]) - (e[7] + e[6]);
            bbu = (e[4] + e[5]) - (e[0] + e[6]);
            bbv = (e[0] + e[4]) - (e[6] + e[5]);
            pp = 2 * SIZE_X;
            qq = 2 * SIZE_Z;
            p3 = pp * pp * pp;
            q3 = qq * qq * qq;
            den = 4 * p3 * pp * q3 * qq;
            for (int z = 0; z < SIZE_Z; z++) begin
                q = 2 * z + 1;
                fv = q * q * (3 * qq - 2 * q);
                for (int x = 0; x < SIZE_X; x++) begin
                    p = 2 * x + 1;
                    fu = p * p * (3 * pp - 2 * p);
                    n4 = plane(s4, bau, p, bav, q, pp, qq);
                    n3 = plane(s3, bbu, p - pp, bbv, q, pp, qq);
                    n1 = plane(s1, aau, p, aav, q - qq, pp, qq);
                    n2 = plane(s2, abu, p - pp, abv, q - qq, pp, qq);
                    num = (q3 - fv) * ((p3 - fu) * n4 + fu * n3)
                        + fv * ((p3 - fu) * n1 + fu * n2);
                    hh = num / den;
                    if (hh > 32767) hh = 32767;
                    if (hh < -32768) hh = -32768;
                    c.h = hh[15:0];
                    c.col = x[2:0];
                    c.row = z[2:0];
                    c.last = (x == SIZE_X - 1) && (z == SIZE_Z - 1);
                    pending.push_back(c);
                end
            end
        endfunction

        function void check_subcell(logic [23:0] d, logic lst);
            subcell_t want;
            subcell_t got;
            got = {d[15:0], d[18:16], d[21:19], lst};
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected item %h", d);
                return;
            end
            want = pending.pop_front();
            if (got !== want || d[23:22] !== 2'b00) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: h %0d/%0d col %0d/%0d row %0d/%0d last %0b/%0b (exp/act)",
                             $signed(want.h), $signed(got.h), want.col, got.col,
                             want.row, got.row, want.last, got.last);
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    logic         m_tlast;

    height_board board;
    logic        feed_done;
    logic        hold_off;
    int          cells_sent;
    int          idle_cycles;

    terrain_subcell_height_interpolator_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // centre, nw, n, ne, e, se, s, sw, w: 16 bits each, lowest first
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // sub_height [15:0], col_index [18:16], row_index [21:19], zero pad
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Offer one cell and hold it until the block takes it.
    task automatic send_cell(input logic [143:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_cell(d);
        cells_sent++;
    endtask

    task automatic pause_feed(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Pick a height biased toward the extremes and small values.
    function automatic logic [15:0] pick_height();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_uniform(input logic [15:0] v);
        send_cell({9{v}});
    endtask

    // Stimulus: directed cells first, then random bursts.
    initial begin
        logic [143:0] d;
        int burst;
        board = new();
        feed_done = 1'b0;
        cells_sent = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // flat cells at zero, all ones, the extremes and alternating bit patterns
        send_uniform(16'h0000);
        send_uniform(16'h7fff);
        send_uniform(16'h8000);
        send_uniform(16'h5555);
        send_uniform(16'haaaa);
        send_uniform(16'hffff);
        // one height at a time (centre included) set to the top, rest at the bottom
        for (int k = 0; k < 9; k++) begin
            d = {9{16'h8000}};
            d[16*k +: 16] = 16'h7fff;
            send_cell(d);
        end
        // checkerboard of extremes, which gives the steepest slopes
        send_cell({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                   16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
        send_cell({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                   16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        pause_feed(3);
        while (cells_sent < 17 + RAND_CELLS) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst; b++) begin
                for (int k = 0; k < 9; k++) d[16*k +: 16] = pick_height();
                send_cell(d);
            end
            if ($urandom_range(0, 3) != 0) pause_feed($urandom_range(1, 90));
        end
        s_tvalid <= 1'b0;
        feed_done = 1'b1;
    end

    // Receiver: random stalls, stretches of none, and one long hold-off.
    initial begin
        int mode;
        hold_off = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (cells_sent == 40 && !hold_off) begin
                // Hold off long enough that the chain fills and stalls input.
                hold_off = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            mode = (cells_sent / 25) % 3;
            if (mode == 0) m_tready <= 1'b1;
            else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 1) != 0);
        end
    end

    // Check every accepted result item.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_subcell(m_tdata, m_tlast);
    end

    // Watchdog and end of run.
    initial begin
        idle_cycles = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (feed_done && board.pending.size() == 0) begin
                repeat (20) @(posedge aclk);
                $display("Run covered %0d cells and %0d sub-cell results,",
                         cells_sent, board.checked);
                $display("with flat, extreme and random heights under backpressure.");
                if (board.errors == 0 && !m_tvalid) begin
                    $display("Testbench completed without errors");
                end else begin
                    $display("%0d mismatches", board.errors);
                    $display("Testbench completed WITH ERRORS");
                end
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
